[hw/rtl/packbits_line_decoder_unit_defines.svh]
// assertion macros for the packbits line decoder
`ifndef PACKBITS_LINE_DECODER_UNIT_DEFINES_SVH
`define PACKBITS_LINE_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PLBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PLBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define PLBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/plbd_pkg.sv]
package plbd_pkg;

    localparam logic [7:0] LINE_BYTES_RESET = 8'd72;
    localparam logic [7:0] LINE_BYTES_MAX   = 8'd128;
    localparam logic [7:0] HDR_NOP          = 8'd128;

    // decoder phase codes
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_REPEAT = 2'd2;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] remaining;
        logic [6:0] column;
    } t_state;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [7:0] run_count;
        logic [6:0] start_column;
        logic       line_end;
    } t_result;

endpackage

[hw/rtl/plbd_step.sv]
module plbd_step (
    input  plbd_pkg::t_state  i_state,
    input  logic [7:0]        i_line_len,
    input  logic [7:0]        i_byte,
    output plbd_pkg::t_state  o_state,
    output logic              o_res_valid,
    output plbd_pkg::t_result o_res
);
    import plbd_pkg::*;

    logic [7:0] run;
    logic [7:0] col_next;
    logic       at_end;
    logic [6:0] col_emit;
    logic [6:0] col_hdr;
    logic [7:0] room;
    logic [7:0] count;
    logic [7:0] rem_dec;
    logic       is_data;

    assign is_data = (i_state.phase == PH_LITERAL) || (i_state.phase == PH_REPEAT);

    // data beat: literal is one byte, repeat uses the clipped count
    always_comb begin
        if (i_state.phase == PH_LITERAL) begin
            run = 8'd1;
        end else if (i_state.remaining == 8'd0) begin
            run = 8'd1;
        end else begin
            run = i_state.remaining;
        end
    end

    assign col_next = {1'b0, i_state.column} + run;
    assign at_end   = (col_next >= i_line_len);
    assign col_emit = at_end ? 7'd0 : col_next[6:0];
    assign rem_dec  = i_state.remaining - 8'd1;

    // header beat: wrap a stale column, then clip to the room left
    assign col_hdr = ({1'b0, i_state.column} >= i_line_len) ? 7'd0 : i_state.column;
    assign room    = i_line_len - {1'b0, col_hdr};

    always_comb begin
        if (!i_byte[7]) begin
            count = i_byte + 8'd1;
        end else begin
            count = 8'd0 - i_byte + 8'd1;
        end
        if (count > room) begin
            count = room;
        end
    end

    always_comb begin
        o_state            = i_state;
        o_res_valid        = is_data;
        o_res.pixel_byte   = i_byte;
        o_res.run_count    = run;
        o_res.start_column = i_state.column;
        o_res.line_end     = at_end;
        case (i_state.phase)
            PH_LITERAL: begin
                o_state.column    = col_emit;
                o_state.remaining = rem_dec;
                if ((rem_dec == 8'd0) || (col_emit == 7'd0)) begin
                    o_state.phase     = PH_HEADER;
                    o_state.remaining = 8'd0;
                end
            end
            PH_REPEAT: begin
                o_state.column    = col_emit;
                o_state.phase     = PH_HEADER;
                o_state.remaining = 8'd0;
            end
            default: begin
                o_state.column = col_hdr;
                o_state.phase  = PH_HEADER;
                if (i_byte != HDR_NOP) begin
                    o_state.remaining = count;
                    o_state.phase     = i_byte[7] ? PH_REPEAT : PH_LITERAL;
                end
            end
        endcase
    end

endmodule

[hw/rtl/plbd_out_reg.sv]
module plbd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  plbd_pkg::t_result i_res,
    input  logic              i_take,
    output logic              o_valid,
    output plbd_pkg::t_result o_res
);
    import plbd_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[hw/rtl/packbits_line_decoder_unit.sv]
// packbits line decoder: takes a compressed 1-bit bitmap stream one byte per
// beat and decodes it with packbits run-length coding, one line at a time.
// header 0..127 starts a literal run of header+1 bytes, 129..255 repeats the
// next byte 257-header times, 128 is skipped. runs are clipped at the line
// length set through the cfg port (1..128 bytes, 0 acts as 1 and values above
// 128 act as 128, reset 72). each data byte gives one output beat with the
// byte, its run length, its start column and a line-end flag; header bytes
// give no beat. throughput is one stream byte per clock while the output is
// not stalled: a byte is held in the input register and is decoded in a
// single pass against the phase/remaining/column state into the output
// register. while a decoded beat waits in the output register without
// i_out_ready, the held byte does not move on and o_in_ready drops, header
// bytes included.
module packbits_line_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // cfg: line length in bytes
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    // compressed stream in
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_stream_byte,
    // decoded runs out
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_pixel_byte,
    output logic [7:0] o_run_count,
    output logic [6:0] o_start_column,
    output logic       o_line_end
);
    import plbd_pkg::*;

    `include "packbits_line_decoder_unit_defines.svh"

    logic [7:0] r_line_bytes;
    logic [7:0] line_len;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // decoder state
    t_state     r_state;
    t_state     n_state;

    logic       res_valid;
    t_result    res;
    t_result    out_res;
    logic       advance;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes <= LINE_BYTES_RESET;
        end else if (i_cfg_we) begin
            r_line_bytes <= i_cfg_data;
        end
    end

    // clamp the programmed length to 1..128
    always_comb begin
        if (r_line_bytes == 8'd0) begin
            line_len = 8'd1;
        end else if (r_line_bytes > LINE_BYTES_MAX) begin
            line_len = LINE_BYTES_MAX;
        end else begin
            line_len = r_line_bytes;
        end
    end

    // the held byte moves on when the output slot is free or being emptied
    assign advance    = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_stream_byte;
        end
    end

    plbd_step u_step (
        .i_state     (r_state),
        .i_line_len  (line_len),
        .i_byte      (r_in_byte),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    plbd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .i_take  (i_out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_pixel_byte   = out_res.pixel_byte;
    assign o_run_count    = out_res.run_count;
    assign o_start_column = out_res.start_column;
    assign o_line_end     = out_res.line_end;

    // a literal run in progress always has bytes left
    `PLBD_ASSERT_NOW(a_lit_has_bytes, i_clk, i_rst_n,
        r_state.phase == PH_LITERAL, r_state.remaining != 8'd0,
        "literal phase with no bytes remaining")

    // a data byte that moves on always lands in the output register
    `PLBD_ASSERT_NEXT(a_data_gives_beat, i_clk, i_rst_n,
        advance && (r_state.phase == PH_LITERAL || r_state.phase == PH_REPEAT),
        o_out_valid, "data byte produced no output beat")

    // a header byte never creates an output beat
    `PLBD_ASSERT_NEXT(a_header_silent, i_clk, i_rst_n,
        advance && i_out_ready && !(r_state.phase == PH_LITERAL ||
        r_state.phase == PH_REPEAT), !o_out_valid,
        "header byte produced an output beat")

endmodule

[test/plbd_checker.sv]
module plbd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_stream_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_pixel_byte,
    input  logic [7:0] i_run_count,
    input  logic [6:0] i_start_column,
    input  logic       i_line_end,
    output int         o_fail_count,
    output int         o_runs_pending,
    output int         o_runs_checked
);
    import plbd_pkg::*;

    // own copy of the decoder state and the line length register
    logic [7:0] line_len_reg;
    logic [1:0] dec_phase;
    logic [7:0] dec_remaining;
    logic [7:0] dec_column;

    t_result runs_due[$];
    int      mismatches = 0;
    int      runs_pending = 0;
    int      runs_checked = 0;

    assign o_fail_count   = mismatches;
    assign o_runs_pending = runs_pending;
    assign o_runs_checked = runs_checked;

    // 0 acts as 1, anything above 128 as 128
    function automatic int line_len();
        if (line_len_reg == 8'd0) return 1;
        if (line_len_reg > LINE_BYTES_MAX) return int'(LINE_BYTES_MAX);
        return int'(line_len_reg);
    endfunction

    task automatic place_run(input logic [7:0] value, input int run, output t_result res);
        int len;
        int next;
        len = line_len();
        next = int'(dec_column) + run;
        res.pixel_byte   = value;
        res.run_count    = run[7:0];
        res.start_column = dec_column[6:0];
        res.line_end     = (next >= len);
        dec_column = res.line_end ? 8'd0 : next[7:0];
    endtask

    task automatic decode_byte(input logic [7:0] b, output logic hit, output t_result res);
        int len;
        int room;
        int count;
        len = line_len();
        hit = 1'b0;
        res = '0;
        case (dec_phase)
            PH_LITERAL: begin
                place_run(b, 1, res);
                hit = 1'b1;
                dec_remaining = dec_remaining - 8'd1;
                // run done, or the line closed early under a shorter length
                if (dec_remaining == 8'd0 || dec_column == 8'd0) begin
                    dec_phase = PH_HEADER;
                    dec_remaining = 8'd0;
                end
            end
            PH_REPEAT: begin
                place_run(b, (dec_remaining == 8'd0) ? 1 : int'(dec_remaining), res);
                hit = 1'b1;
                dec_phase = PH_HEADER;
                dec_remaining = 8'd0;
            end
            default: begin
                dec_phase = PH_HEADER;
                if (int'(dec_column) >= len) dec_column = 8'd0;
                if (b != HDR_NOP) begin
                    room = len - int'(dec_column);
                    count = (b < HDR_NOP) ? int'(b) + 1 : 257 - int'(b);
                    if (count > room) count = room;
                    dec_remaining = count[7:0];
                    dec_phase = (b < HDR_NOP) ? PH_LITERAL : PH_REPEAT;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result fresh;
        t_result oldest;
        logic    hit;
        if (!i_rst_n) begin
            line_len_reg  = LINE_BYTES_RESET;
            dec_phase     = PH_HEADER;
            dec_remaining = 8'd0;
            dec_column    = 8'd0;
            runs_due.delete();
        end else begin
            if (i_cfg_we) line_len_reg = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_stream_byte, hit, fresh);
                if (hit) runs_due = {runs_due, fresh};
            end
            if (i_out_valid && i_out_ready) begin
                if (runs_due.size() == 0) begin
                    $error("unexpected run: pixel_byte %0d with nothing pending", i_pixel_byte);
                    mismatches++;
                end else begin
                    oldest = runs_due.pop_front();
                    check_field("pixel_byte", oldest.pixel_byte, i_pixel_byte);
                    check_field("run_count", oldest.run_count, i_run_count);
                    check_field("start_column", oldest.start_column, i_start_column);
                    check_field("line_end", oldest.line_end, i_line_end);
                    runs_checked++;
                end
            end
        end
        runs_pending = runs_due.size();
    end

endmodule

[test/tb.sv]
module tb;
    import plbd_pkg::*;

    // generous bound, well above the slowest legal run
    localparam int CYCLE_LIMIT  = 600000;
    // cycles to let a header beat clear the two-stage pipe before a cfg write
    localparam int SETTLE       = 4;
    localparam int RANDOM_BYTES = 1500;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] stream_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] pixel_byte;
    logic [7:0] run_count;
    logic [6:0] start_column;
    logic       line_end;

    int fail_count;
    int runs_pending;
    int runs_checked;

    int cycles     = 0;
    int bytes_sent = 0;
    int cfg_writes = 0;
    // when set, neither side inserts gaps or stalls
    bit calm       = 1'b0;

    // generator's view of the line, used only to keep runs well formed
    int gen_len    = 72;
    int gen_col    = 0;

    packbits_line_decoder_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_stream_byte  (stream_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_pixel_byte   (pixel_byte),
        .o_run_count    (run_count),
        .o_start_column (start_column),
        .o_line_end     (line_end)
    );

    plbd_checker chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_stream_byte  (stream_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_pixel_byte   (pixel_byte),
        .i_run_count    (run_count),
        .i_start_column (start_column),
        .i_line_end     (line_end),
        .o_fail_count   (fail_count),
        .o_runs_pending (runs_pending),
        .o_runs_checked (runs_checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // output side: random stalls, changed only at the falling edge
    initial begin : sink
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // one stream beat; valid stays up with the same byte until taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        stream_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // hold the stream until every predicted run has come out, then let the
    // pipe settle so a trailing header beat is fully absorbed
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (runs_pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_len(input logic [7:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // one well-formed run: header plus exactly the data bytes the clipped
    // count will consume
    task automatic send_run(input bit literal, input int n);
        int room;
        int take;
        if (gen_col >= gen_len) gen_col = 0;
        room = gen_len - gen_col;
        take = (n < room) ? n : room;
        if (literal) begin
            send_byte(8'(n - 1));
            repeat (take) send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(8'(257 - n));
            send_byte(8'($urandom_range(0, 255)));
        end
        gen_col = (gen_col + take >= gen_len) ? 0 : gen_col + take;
    endtask

    // force a known state: with a one-byte line a data byte closes the run
    // and a no-op header leaves the header phase as it is, so either way
    // the decoder ends up expecting a header at column 0
    task automatic resync(input logic [7:0] len);
        write_len(8'd1);
        send_byte(HDR_NOP);
        write_len(len);
        gen_len = (len == 8'd0) ? 1 : ((len > LINE_BYTES_MAX) ? 128 : int'(len));
        gen_col = 0;
    endtask

    initial begin : stimulus
        int target;
        int runs;
        int r;
        int n;
        logic [7:0] len;
        bit broken;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 8'd0;
        in_valid = 1'b0;
        stream_byte = 8'd0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, reset line length of 72
        // literal of one carrying an all-white byte
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR_NOP);
        // longest repeat, clipped to the 71 bytes left on the line
        send_byte(8'h81);
        send_byte(8'hAA);
        // repeat of two with an all-black byte
        send_byte(8'hFF);
        send_byte(8'h00);
        // literal of two whose last byte has the no-op value as data
        send_byte(8'h01);
        send_byte(8'h55);
        send_byte(8'h80);
        // length 0 acts as 1: column past the end restarts, literal clipped
        write_len(8'd0);
        send_byte(8'h05);
        send_byte(8'h33);
        // length above 128 acts as 128: full-line repeat
        write_len(8'd255);
        send_byte(8'h81);
        send_byte(8'h3C);
        // line shortened in the middle of a literal run
        write_len(8'd10);
        send_byte(8'h05);
        send_byte(8'h11);
        send_byte(8'h22);
        write_len(8'd2);
        send_byte(8'h44);
        // repeat set up under one length keeps its count under another
        send_byte(8'h84);
        write_len(8'd128);
        send_byte(8'h66);
        // column already past the new length when a header arrives
        write_len(8'd1);
        send_byte(8'h7F);
        send_byte(8'h77);

        // random part: phases of well-formed runs, some ending in noise
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            r = $urandom_range(0, 9);
            if (r < 4) len = 8'($urandom_range(1, 8));
            else if (r < 8) len = 8'($urandom_range(1, 128));
            else if (r == 8) len = ($urandom_range(0, 1) != 0) ? LINE_BYTES_MAX : 8'd1;
            else len = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(129, 255));
            resync(len);
            calm = ($urandom_range(0, 4) == 0);
            runs = $urandom_range(5, 30);
            broken = 1'b0;
            while (runs > 0 && !broken && bytes_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    n = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4) : $urandom_range(1, 128);
                    send_run(1'b1, n);
                end else if (r < 88) begin
                    n = ($urandom_range(0, 1) != 0) ? $urandom_range(2, 8) : $urandom_range(2, 128);
                    send_run(1'b0, n);
                end else if (r < 94) begin
                    send_byte(HDR_NOP);
                end else begin
                    // raw noise, the next phase resyncs
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                    broken = 1'b1;
                end
                runs--;
            end
            calm = 1'b0;
        end

        drain();
        $display("sent %0d stream beats under %0d line-length writes, %0d runs checked",
                 bytes_sent, cfg_writes, runs_checked);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/plbd_pkg.sv
hw/rtl/plbd_step.sv
hw/rtl/plbd_out_reg.sv
hw/rtl/packbits_line_decoder_unit.sv
test/plbd_checker.sv
test/tb.sv
